@@ src/qgi_pkg.sv @@
package qgi_pkg;

   // shared unit operand and result widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SUB_W   = 34;

   // configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_DT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_X  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_Y  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_Z  = 8'd3;

   // rate and quaternion component selects
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] COMP_W = 2'd0;
   localparam logic [1:0] COMP_X = 2'd1;
   localparam logic [1:0] COMP_Y = 2'd2;
   localparam logic [1:0] COMP_Z = 2'd3;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] mul_a;
      logic signed [MUL_B_W-1:0] mul_b;
      logic [SUB_W-1:0]          sub_a;
      logic [SUB_W-1:0]          sub_b;
   } alu_req_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic [SUB_W-1:0]         diff;
      logic                     borrow;
   } alu_rsp_type;

   // one product term of the quaternion rate: rate axis, quaternion component, sign
   typedef struct packed {
      logic [1:0] w_sel;
      logic [1:0] q_sel;
      logic       neg;
   } term_type;

   // terms of Omega(w)*q, three per output component
   function automatic term_type term_lookup(input logic [1:0] comp, input logic [1:0] idx);
      term_type t;
      t = '{w_sel: AXIS_X, q_sel: COMP_W, neg: 1'b0};
      unique case ({comp, idx})
         {COMP_W, 2'd0}: t = '{w_sel: AXIS_X, q_sel: COMP_X, neg: 1'b1};
         {COMP_W, 2'd1}: t = '{w_sel: AXIS_Y, q_sel: COMP_Y, neg: 1'b1};
         {COMP_W, 2'd2}: t = '{w_sel: AXIS_Z, q_sel: COMP_Z, neg: 1'b1};
         {COMP_X, 2'd0}: t = '{w_sel: AXIS_X, q_sel: COMP_W, neg: 1'b0};
         {COMP_X, 2'd1}: t = '{w_sel: AXIS_Z, q_sel: COMP_Y, neg: 1'b0};
         {COMP_X, 2'd2}: t = '{w_sel: AXIS_Y, q_sel: COMP_Z, neg: 1'b1};
         {COMP_Y, 2'd0}: t = '{w_sel: AXIS_Y, q_sel: COMP_W, neg: 1'b0};
         {COMP_Y, 2'd1}: t = '{w_sel: AXIS_Z, q_sel: COMP_X, neg: 1'b1};
         {COMP_Y, 2'd2}: t = '{w_sel: AXIS_X, q_sel: COMP_Z, neg: 1'b0};
         {COMP_Z, 2'd0}: t = '{w_sel: AXIS_Z, q_sel: COMP_W, neg: 1'b0};
         {COMP_Z, 2'd1}: t = '{w_sel: AXIS_Y, q_sel: COMP_X, neg: 1'b0};
         {COMP_Z, 2'd2}: t = '{w_sel: AXIS_X, q_sel: COMP_Y, neg: 1'b1};
         default:        t = '{w_sel: AXIS_X, q_sel: COMP_W, neg: 1'b0};
      endcase
      return t;
   endfunction

   // clamp to the signed 16-bit range
   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ src/quaternion_gyro_integrator_top.sv @@
// A request runs the first-order step, the sum of squares, the square root and its
// rounding, then a divide per component and the hand-off; when the sum of squares is
// zero, the square root and the divides are skipped. The multiplier and subtractor are
// shared by all steps; one request at a time, a new one is taken only when idle.
// Reset restores half_dt = 164, zero biases and the identity attitude.
module quaternion_gyro_integrator_top
   import qgi_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [15:0]   req_gyro_x,
   input  logic signed [15:0]   req_gyro_y,
   input  logic signed [15:0]   req_gyro_z,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_quat_w,
   output logic signed [15:0]   rsp_quat_x,
   output logic signed [15:0]   rsp_quat_y,
   output logic signed [15:0]   rsp_quat_z
);

   localparam int QB    = QUAT_FRAC_BITS + 1;
   localparam int DIV_W = QUAT_FRAC_BITS + 17;
   localparam int CNT_W = $clog2(QB + 1);
   localparam logic [15:0] UNIT =
      (QUAT_FRAC_BITS >= 15) ? 16'h7FFF : 16'(1 << QUAT_FRAC_BITS);
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd134217728);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_SCALE, ST_UPD, ST_SQ, ST_SQRT, ST_ROUND,
      ST_DIVLD, ST_DIV, ST_DIVST, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]        half_dt_ff, half_dt_in;
   logic signed [15:0] bias_x_ff, bias_x_in;
   logic signed [15:0] bias_y_ff, bias_y_in;
   logic signed [15:0] bias_z_ff, bias_z_in;
   logic signed [15:0] w_ff [3];
   logic signed [15:0] w_in [3];
   logic signed [15:0] q_ff [4];
   logic signed [15:0] q_in [4];
   logic signed [15:0] nq_ff [4];
   logic signed [15:0] nq_in [4];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         ci_ff, ci_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] acc_ff, acc_in;
   logic [32:0]        ss_ff, ss_in;
   logic [SUB_W-1:0]   rem_ff, rem_in;
   logic [SUB_W-1:0]   res_ff, res_in;
   logic [32:0]        bit_ff, bit_in;
   logic [16:0]        n_ff, n_in;
   logic [QB-1:0]      sh_ff, sh_in;
   logic [QB-1:0]      qt_ff, qt_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   term_type           term;
   logic signed [15:0] w_sel_val;
   logic signed [PROD_W-1:0] rnd;
   logic signed [23:0] dq;
   logic signed [15:0] upd_val;
   logic signed [15:0] nq_cur;
   logic [15:0]        mag;
   logic [DIV_W-1:0]   dividend;
   logic [31:0]        qt_ext;
   logic signed [15:0] div_val;
   logic [32:0]        ss_sum;
   logic               req_fire;

   qgi_alu u_alu (
      .clock (clock),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = q_ff[COMP_W];
   assign rsp_quat_x = q_ff[COMP_X];
   assign rsp_quat_y = q_ff[COMP_Y];
   assign rsp_quat_z = q_ff[COMP_Z];

   // product term for the current component and step
   assign term = term_lookup(ci_ff, cnt_ff[1:0]);

   always_comb begin
      case (term.w_sel)
         AXIS_X:  w_sel_val = w_ff[0];
         AXIS_Y:  w_sel_val = w_ff[1];
         default: w_sel_val = w_ff[2];
      endcase
   end

   // round the scaled increment half up and add it to the old component
   assign rnd     = alu_rsp.prod + RND_HALF;
   assign dq      = rnd[PROD_W-1:28];
   assign upd_val = sat16(32'(q_ff[ci_ff]) + 32'(dq));

   // dividend for normalising: |nq| * 2^F plus half the norm
   assign nq_cur   = nq_ff[ci_ff];
   assign mag      = nq_cur[15] ? 16'(16'd0 - nq_cur) : nq_cur;
   assign dividend = (DIV_W'(mag) << QUAT_FRAC_BITS) + DIV_W'(n_ff >> 1);

   // saturate the signed quotient
   assign qt_ext = 32'(qt_ff);
   always_comb begin
      if (!nq_cur[15]) begin
         div_val = (qt_ext > 32'd32767) ? 16'sh7FFF : $signed(qt_ext[15:0]);
      end else begin
         div_val = (qt_ext > 32'd32768) ? 16'sh8000 : $signed(16'(16'd0 - qt_ext[15:0]));
      end
   end

   assign ss_sum = ss_ff + alu_rsp.prod[32:0];

   always_comb begin
      state_in     = state_ff;
      half_dt_in   = half_dt_ff;
      bias_x_in    = bias_x_ff;
      bias_y_in    = bias_y_ff;
      bias_z_in    = bias_z_ff;
      w_in         = w_ff;
      q_in         = q_ff;
      nq_in        = nq_ff;
      rsp_valid_in = rsp_valid_ff;
      ci_in        = ci_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      ss_in        = ss_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      n_in         = n_ff;
      sh_in        = sh_ff;
      qt_in        = qt_ff;
      alu_req      = '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_DT: half_dt_in = csr_data;
            CSR_BIAS_X:  bias_x_in  = $signed(csr_data);
            CSR_BIAS_Y:  bias_y_in  = $signed(csr_data);
            CSR_BIAS_Z:  bias_z_in  = $signed(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               w_in[0]  = sat16(32'(req_gyro_x) - 32'(bias_x_ff));
               w_in[1]  = sat16(32'(req_gyro_y) - 32'(bias_y_ff));
               w_in[2]  = sat16(32'(req_gyro_z) - 32'(bias_z_ff));
               ci_in    = COMP_W;
               cnt_in   = '0;
               state_in = ST_PROD;
            end
         end

         // three rate products per component, each accumulated in the cycle after it is issued
         ST_PROD: begin
            alu_req.mul_a = MUL_A_W'(w_sel_val);
            alu_req.mul_b = MUL_B_W'(q_ff[term.q_sel]);
            neg_in        = term.neg;
            if (cnt_ff == '0) begin
               acc_in = '0;
            end else if (neg_ff) begin
               acc_in = acc_ff - $signed(alu_rsp.prod[33:0]);
            end else begin
               acc_in = acc_ff + $signed(alu_rsp.prod[33:0]);
            end
            if (cnt_ff == CNT_W'(3)) begin
               state_in = ST_SCALE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // scale the sum by half_dt
         ST_SCALE: begin
            alu_req.mul_a = acc_ff;
            alu_req.mul_b = $signed({2'b00, half_dt_ff});
            state_in      = ST_UPD;
         end

         ST_UPD: begin
            nq_in[ci_ff] = upd_val;
            cnt_in       = '0;
            if (ci_ff == COMP_Z) begin
               state_in = ST_SQ;
            end else begin
               ci_in    = ci_ff + 1'b1;
               state_in = ST_PROD;
            end
         end

         // sum of squares, each product accumulated in the cycle after it is issued
         ST_SQ: begin
            alu_req.mul_a = MUL_A_W'(nq_ff[cnt_ff[1:0]]);
            alu_req.mul_b = MUL_B_W'(nq_ff[cnt_ff[1:0]]);
            if (cnt_ff == '0) begin
               ss_in = '0;
            end else begin
               ss_in = ss_sum;
            end
            if (cnt_ff == CNT_W'(4)) begin
               if (ss_sum == '0) begin
                  state_in = ST_OUT;
               end else begin
                  rem_in   = SUB_W'(ss_sum);
                  res_in   = '0;
                  bit_in   = 33'h1_0000_0000;
                  state_in = ST_SQRT;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // one result bit per cycle
         ST_SQRT: begin
            alu_req.sub_a = rem_ff;
            alu_req.sub_b = res_ff + SUB_W'(bit_ff);
            if (!alu_rsp.borrow) begin
               rem_in = alu_rsp.diff;
               res_in = (res_ff >> 1) + SUB_W'(bit_ff);
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_ROUND;
            end
         end

         // round the root up when the remainder exceeds it
         ST_ROUND: begin
            alu_req.sub_a = res_ff;
            alu_req.sub_b = rem_ff;
            n_in          = res_ff[16:0] + 17'(alu_rsp.borrow);
            ci_in         = COMP_W;
            state_in      = ST_DIVLD;
         end

         ST_DIVLD: begin
            rem_in   = SUB_W'(dividend[DIV_W-1:QB]);
            sh_in    = dividend[QB-1:0];
            qt_in    = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            alu_req.sub_a = {16'd0, rem_ff[16:0], sh_ff[QB-1]};
            alu_req.sub_b = SUB_W'(n_ff);
            if (!alu_rsp.borrow) begin
               rem_in = SUB_W'(alu_rsp.diff[16:0]);
            end else begin
               rem_in = SUB_W'({rem_ff[15:0], sh_ff[QB-1]});
            end
            sh_in = sh_ff << 1;
            qt_in = {qt_ff[QB-2:0], ~alu_rsp.borrow};
            if (cnt_ff == CNT_W'(QB - 1)) begin
               state_in = ST_DIVST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_DIVST: begin
            nq_in[ci_ff] = div_val;
            if (ci_ff == COMP_Z) begin
               state_in = ST_OUT;
            end else begin
               ci_in    = ci_ff + 1'b1;
               state_in = ST_DIVLD;
            end
         end

         // hold until the previous result has gone, then advance the attitude
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               q_in         = nq_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         half_dt_ff   <= 16'd164;
         bias_x_ff    <= '0;
         bias_y_ff    <= '0;
         bias_z_ff    <= '0;
         q_ff[COMP_W] <= $signed(UNIT);
         q_ff[COMP_X] <= '0;
         q_ff[COMP_Y] <= '0;
         q_ff[COMP_Z] <= '0;
         rsp_valid_ff <= 1'b0;
         ci_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         half_dt_ff   <= half_dt_in;
         bias_x_ff    <= bias_x_in;
         bias_y_ff    <= bias_y_in;
         bias_z_ff    <= bias_z_in;
         q_ff         <= q_in;
         rsp_valid_ff <= rsp_valid_in;
         ci_ff        <= ci_in;
         cnt_ff       <= cnt_in;
      end
      w_ff   <= w_in;
      nq_ff  <= nq_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      ss_ff  <= ss_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      n_ff   <= n_in;
      sh_ff  <= sh_in;
      qt_ff  <= qt_in;
   end

endmodule

@@ src/qgi_alu.sv @@
module qgi_alu
   import qgi_pkg::*;
(
   input  logic        clock,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic signed [PROD_W-1:0] prod_ff;
   logic [SUB_W:0]           diff_full;

   // registered multiply
   always_ff @(posedge clock) begin
      prod_ff <= req.mul_a * req.mul_b;
   end

   // subtract and compare, borrow marks a < b
   assign diff_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};

   assign rsp.prod   = prod_ff;
   assign rsp.diff   = diff_full[SUB_W-1:0];
   assign rsp.borrow = diff_full[SUB_W];

endmodule
